// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam int VALUE_W  = 32;
    localparam int PRI_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_ENQ   = 2'd0;
    localparam t_status ST_DEQ   = 2'd1;
    localparam t_status ST_UNDER = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic signed [PRI_W-1:0]   pri;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

endpackage

// ===== rtl/core/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if
// Request channel: enqueue or dequeue item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_in_if;

    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [spq_pkg::VALUE_W-1:0]  item_value;
    logic signed [spq_pkg::PRI_W-1:0]    item_priority;

    modport source (
        output valid, opcode, item_value, item_priority,
        input  ready
    );

    modport sink (
        input  valid, opcode, item_value, item_priority,
        output ready
    );

endinterface

// ===== rtl/core/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// spq_out_if
// Result channel: status, removed entry and fill level per item.
// ----------------------------------------------------------------------------
interface spq_out_if;

    logic                                valid;
    logic                                ready;
    logic [spq_pkg::STATUS_W-1:0]        status;
    logic signed [spq_pkg::VALUE_W-1:0]  out_value;
    logic signed [spq_pkg::PRI_W-1:0]    out_priority;
    logic [spq_pkg::COUNT_W-1:0]         entry_count;
    logic                                is_empty;

    modport source (
        output valid, status, out_value, out_priority, entry_count, is_empty,
        input  ready
    );

    modport sink (
        input  valid, status, out_value, out_priority, entry_count, is_empty,
        output ready
    );

endinterface

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in descending priority order in a small RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per request: opcode 0 enqueues item_value with
//   item_priority, opcode 1 dequeues the head entry. o_out returns one item
//   per request: status, the removed entry (zero unless dequeued), and the
//   fill level after the request.
//   Entries sit in one single-port-write RAM; a sequencer walks it with one
//   priority comparator, one entry at a time (read, then compare and
//   move). Enqueue scans from the tail up to the insert slot, moving each
//   lower entry back, then writes the new entry; an empty queue takes it at once.
//   Dequeue moves every entry forward. Full and underflow requests go
//   straight to the result state. i_in.ready is high only while idle, so
//   one request is in work at a time.
//   The result register decouples the channels: the next request is taken
//   while a result still waits; a finished result waits in the sequencer
//   until the register frees up.
//   Reset empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_INS,
        S_RES
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_op, n_op;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic signed [PRI_W-1:0]   r_pri, n_pri;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [OCC_W-1:0]          r_occ, n_occ;
    t_status                   r_status, n_status;
    logic signed [VALUE_W-1:0] r_rv, n_rv;
    logic signed [PRI_W-1:0]   r_rp, n_rp;

    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status, n_out_status;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic signed [PRI_W-1:0]   r_out_pri, n_out_pri;
    logic [COUNT_W-1:0]        r_out_count, n_out_count;
    logic                      r_out_empty, n_out_empty;

    t_entry                    r_mem [CAPACITY];
    t_entry                    r_rd;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    t_entry                    mem_wdata;

    logic                      accept;
    logic [IDX_W-1:0]          idx_last;
    logic [IDX_W-1:0]          idx_next;
    logic                      stop;
    logic                      out_free;
    logic [OCC_W-1:0]          occ_res;

    assign i_in.ready         = (r_state == S_IDLE);
    assign accept             = i_in.valid && i_in.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.out_value    = r_out_value;
    assign o_out.out_priority = r_out_pri;
    assign o_out.entry_count  = r_out_count;
    assign o_out.is_empty     = r_out_empty;

    assign idx_last = IDX_W'(r_occ - 1'b1);
    assign idx_next = IDX_W'(r_idx + 1'b1);
    assign out_free = !r_out_valid || o_out.ready;

    // Head ties keep the old head in front; elsewhere equal priorities move back.
    assign stop = (r_idx == '0) ? (r_rd.pri >= r_pri) : (r_rd.pri > r_pri);

    always_comb begin
        case (r_status)
            ST_ENQ:  occ_res = OCC_W'(r_occ + 1'b1);
            ST_DEQ:  occ_res = OCC_W'(r_occ - 1'b1);
            default: occ_res = r_occ;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_val        = r_val;
        n_pri        = r_pri;
        n_idx        = r_idx;
        n_occ        = r_occ;
        n_status     = r_status;
        n_rv         = r_rv;
        n_rp         = r_rp;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_pri    = r_out_pri;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = r_rd;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_in.opcode;
                    n_val = i_in.item_value;
                    n_pri = i_in.item_priority;
                    n_rv  = '0;
                    n_rp  = '0;
                    if (i_in.opcode == OP_ENQ) begin
                        n_status = ST_ENQ;
                        if (r_occ == OCC_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_RES;
                        end else if (r_occ == '0) begin
                            n_idx   = '0;
                            n_state = S_INS;
                        end else begin
                            n_idx   = idx_last;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_status = ST_UNDER;
                            n_state  = S_RES;
                        end else begin
                            n_status = ST_DEQ;
                            n_idx    = '0;
                            n_state  = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_op == OP_ENQ) begin
                    if (stop) begin
                        n_idx   = idx_next;
                        n_state = S_INS;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_next;
                        if (r_idx == '0) begin
                            n_state = S_INS;
                        end else begin
                            n_idx   = IDX_W'(r_idx - 1'b1);
                            n_state = S_RD;
                        end
                    end
                end else begin
                    if (r_idx == '0) begin
                        n_rv = r_rd.value;
                        n_rp = r_rd.pri;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(r_idx - 1'b1);
                    end
                    if (r_idx == idx_last) begin
                        n_state = S_RES;
                    end else begin
                        n_idx   = idx_next;
                        n_state = S_RD;
                    end
                end
            end
            S_INS: begin
                mem_we          = 1'b1;
                mem_waddr       = r_idx;
                mem_wdata.value = r_val;
                mem_wdata.pri   = r_pri;
                n_state         = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = r_rv;
                    n_out_pri    = r_rp;
                    n_out_count  = COUNT_W'(occ_res);
                    n_out_empty  = (occ_res == '0);
                    n_occ        = occ_res;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_out_valid  <= n_out_valid;
            r_op         <= n_op;
            r_val        <= n_val;
            r_pri        <= n_pri;
            r_idx        <= n_idx;
            r_status     <= n_status;
            r_rv         <= n_rv;
            r_rp         <= n_rp;
            r_out_status <= n_out_status;
            r_out_value  <= n_out_value;
            r_out_pri    <= n_out_pri;
            r_out_count  <= n_out_count;
            r_out_empty  <= n_out_empty;
        end
    end

    // Entry RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_ins_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_state == S_RES) && (r_status == ST_ENQ))
        else $error("insert did not complete as enqueue");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_DEQ)) |->
            (o_out.out_value == '0) && (o_out.out_priority == '0))
        else $error("nonzero entry on result without dequeue");

endmodule

// ===== sim/spq_order_checker.sv =====
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches the request and result channels of the sorted priority queue,
// keeps a shadow copy of the queue, and compares each result item with the
// one the shadow predicts. Reports the number of mismatches and how many
// results are still owed.
// ----------------------------------------------------------------------------
module spq_order_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_req,
    spq_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    import spq_pkg::*;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRI_W-1:0]   pri;
        logic [COUNT_W-1:0]        count;
        logic                      empty;
    } t_queue_rsp;

    logic signed [VALUE_W-1:0] shadow_val [CAPACITY];
    logic signed [PRI_W-1:0]   shadow_pri [CAPACITY];
    int                        shadow_occ;
    t_queue_rsp                due_results [$];

    initial begin
        shadow_occ   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one request to the shadow queue and returns what the block owes.
    task automatic apply_request(
        input  logic                      op,
        input  logic signed [VALUE_W-1:0] val,
        input  logic signed [PRI_W-1:0]   pri,
        output t_queue_rsp                rsp
    );
        int pos;
        int i;
        rsp = '0;
        if (op == OP_ENQ) begin
            if (shadow_occ >= CAPACITY) begin
                rsp.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_occ && shadow_pri[pos] > pri) pos++;
                // tie with the head lands just behind it
                if (pos == 0 && shadow_occ > 0 && shadow_pri[0] == pri) pos = 1;
                for (i = shadow_occ; i > pos; i--) begin
                    shadow_val[i] = shadow_val[i-1];
                    shadow_pri[i] = shadow_pri[i-1];
                end
                shadow_val[pos] = val;
                shadow_pri[pos] = pri;
                shadow_occ++;
                rsp.status = ST_ENQ;
            end
        end else begin
            if (shadow_occ == 0) begin
                rsp.status = ST_UNDER;
            end else begin
                rsp.value = shadow_val[0];
                rsp.pri   = shadow_pri[0];
                for (i = 1; i < shadow_occ; i++) begin
                    shadow_val[i-1] = shadow_val[i];
                    shadow_pri[i-1] = shadow_pri[i];
                end
                shadow_occ--;
                rsp.status = ST_DEQ;
            end
        end
        rsp.count = shadow_occ[COUNT_W-1:0];
        rsp.empty = (shadow_occ == 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_queue_rsp want;
        t_queue_rsp fresh;
        if (!i_rst_n) begin
            shadow_occ = 0;
            due_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_results.size() == 0) begin
                    $error("result item with none outstanding: status %0h",
                           i_rsp.status);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("out_value", want.value, i_rsp.out_value);
                    check_field("out_priority", 32'(want.pri),
                                32'(i_rsp.out_priority));
                    check_field("entry_count", 32'(want.count),
                                32'(i_rsp.entry_count));
                    check_field("is_empty", 32'(want.empty), 32'(i_rsp.is_empty));
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.opcode, i_req.item_value, i_req.item_priority,
                              fresh);
                due_results.push_back(fresh);
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ===== sim/sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives enqueue and dequeue items into the sorted priority queue: a directed
// pass over extremes, ties, full and empty, then random traffic in phases of
// sender gaps and receiver stalls, with one long receiver hold-off. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
    import spq_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   rx_hold_req;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    spq_order_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_rsp        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("sorted_priority_queue regression: fail");
        $finish;
    end

    // Offer one item, with random gaps first, and wait until it is taken.
    task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] val,
                             input logic signed [PRI_W-1:0] pri);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.item_value    <= val;
        in_ch.item_priority <= pri;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random(input int enq_pct);
        logic                      op;
        logic signed [VALUE_W-1:0] val;
        logic signed [PRI_W-1:0]   pri;
        int                        sel;
        op  = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        val = $urandom();
        sel = $urandom_range(99);
        // narrow priorities make ties common
        if (sel < 50) pri = PRI_W'(int'($urandom_range(6)) - 3);
        else if (sel < 85) pri = PRI_W'($urandom());
        else begin
            case ($urandom_range(3))
                0: pri = 16'sh8000;
                1: pri = 16'sh7fff;
                2: pri = -16'sd1;
                default: pri = '0;
            endcase
        end
        send_item(op, val, pri);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        int hold_left;
        out_ch.ready <= 1'b0;
        forever begin
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
                while (hold_left > 0) begin
                    out_ch.ready <= 1'b0;
                    hold_left--;
                    @(posedge i_clk);
                end
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int idle_tab  [5];
        int stall_tab [5];
        int bias_tab  [4];
        int enq_pct;
        int ph;
        int n;
        idle_tab  = '{0, 82, 0, 25, 0};
        stall_tab = '{0, 0, 82, 25, 0};
        bias_tab  = '{20, 50, 65, 90};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_req    = 0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= OP_ENQ;
        in_ch.item_value    <= '0;
        in_ch.item_priority <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: underflow, extremes, ties at head, middle and tail, full
        send_item(OP_DEQ, $urandom(), PRI_W'($urandom()));
        send_item(OP_ENQ, 32'sh7fffffff, 16'sh7fff);
        send_item(OP_ENQ, 32'sh80000000, 16'sh7fff);
        send_item(OP_ENQ, 32'sd1, 16'sh8000);
        send_item(OP_ENQ, 32'sd2, 16'sd0);
        send_item(OP_ENQ, 32'sd3, 16'sd0);
        send_item(OP_ENQ, -32'sd1, -16'sd1);
        send_item(OP_ENQ, 32'sd4, 16'sh8000);
        send_item(OP_ENQ, 32'sd5, 16'sh7fff);
        for (n = 0; n < 7; n++) begin
            send_item(OP_ENQ, n * 32'h11111111, PRI_W'(n * 1000 - 3000));
        end
        send_item(OP_ENQ, 32'sh5a5a5a5a, 16'sh1234);
        repeat (5) send_item(OP_DEQ, $urandom(), PRI_W'($urandom()));

        for (ph = 0; ph < 5; ph++) begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            // last phase: hold the receiver off so the block backs up
            if (ph == 4) rx_hold_req = 400;
            for (n = 0; n < 330; n++) begin
                if (n % 40 == 0) enq_pct = bias_tab[$urandom_range(3)];
                send_random(enq_pct);
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
